[hdl/acr_pkg.sv]
// Shared constants, types and the controller/datapath command and status structs.
`timescale 1ns / 1ps
package acr_pkg;

  localparam int unsigned SCREEN_WIDTH  = 384;
  localparam int unsigned SCREEN_HEIGHT = 216;
  localparam int unsigned MAX_RADIUS    = 1023;

  localparam int unsigned COORD_W = 12;
  localparam int unsigned RAD_W   = 10;
  localparam int unsigned COL_W   = 16;
  localparam int unsigned PX_W    = 9;
  localparam int unsigned PY_W    = 8;
  localparam int unsigned POSX_W  = 11;
  localparam int unsigned POSY_W  = 12;
  localparam int unsigned ERR_W   = 14;
  localparam int unsigned DIV_W   = 12;
  localparam int unsigned NUM_W   = 16;
  localparam int unsigned SUM_W   = 14;
  localparam int unsigned DVD_W   = 24;
  localparam int unsigned WV_W    = 15;

  localparam logic [POSX_W-1:0] RAD_LIMIT = POSX_W'(MAX_RADIUS);

  // Wrap reduction: offset to make the coordinate positive, then reciprocal multiply.
  localparam int unsigned WRAP_SH  = 20;
  localparam int unsigned OFF_X    = SCREEN_WIDTH * ((8192 + SCREEN_WIDTH - 1) / SCREEN_WIDTH);
  localparam int unsigned OFF_Y    = SCREEN_HEIGHT * ((8192 + SCREEN_HEIGHT - 1) / SCREEN_HEIGHT);
  localparam int unsigned RECIP_X  = ((1 << WRAP_SH) + SCREEN_WIDTH - 1) / SCREEN_WIDTH;
  localparam int unsigned RECIP_Y  = ((1 << WRAP_SH) + SCREEN_HEIGHT - 1) / SCREEN_HEIGHT;

  localparam logic REQ_START = 1'b0;
  localparam logic REQ_STEP  = 1'b1;

  typedef enum logic [1:0] {
    GRP_CURVE = 2'd0,
    GRP_OUTER = 2'd1,
    GRP_INNER = 2'd2
  } grp_e;

  typedef struct packed {
    logic       load_start;
    logic       load_step;
    grp_e       grp;
    logic [1:0] ch;
    logic       blend_start;
    logic       div_store;
    logic [1:0] rec;
    logic       coord_calc;
    logic       out_load;
    logic       out_last;
    logic       out_done;
  } acr_cmd_t;

  typedef struct packed {
    logic req_valid;
    logic req_type;
    logic busy;
    logic div_done;
    logic out_free;
    logic outer_en;
    logic inner_en;
    logic final_step;
  } acr_stat_t;

endpackage

[hdl/acr_req_if.sv]
// Request channel: start and step items.
`timescale 1ns / 1ps
interface acr_req_if import acr_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       req_type;
  logic signed [COORD_W-1:0]  center_x;
  logic signed [COORD_W-1:0]  center_y;
  logic [RAD_W-1:0]           radius;
  logic [COL_W-1:0]           fg_color;
  logic [COL_W-1:0]           bg_color;
  logic                       wrap_mode;

  modport source (output valid, req_type, center_x, center_y, radius, fg_color, bg_color,
                  wrap_mode, input ready);
  modport sink (input valid, req_type, center_x, center_y, radius, fg_color, bg_color,
                wrap_mode, output ready);
endinterface

[hdl/acr_pix_if.sv]
// Pixel channel: one pixel write record per transfer.
`timescale 1ns / 1ps
interface acr_pix_if import acr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PX_W-1:0]  pixel_x;
  logic [PY_W-1:0]  pixel_y;
  logic [COL_W-1:0] pixel_color;
  logic             write_enable;
  logic             step_last;
  logic             circle_done;

  modport source (output valid, pixel_x, pixel_y, pixel_color, write_enable, step_last,
                  circle_done, input ready);
  modport sink (input valid, pixel_x, pixel_y, pixel_color, write_enable, step_last,
                circle_done, output ready);
endinterface

[hdl/antialiased_circle_rasterizer_top.sv]
// Top level of the anti-aliased circle rasterizer.
`timescale 1ns / 1ps
// The request channel (req_i) takes two kinds of item. A start item loads the
// centre, radius, foreground and background colours and the wrap flag; it
// produces no records. Each step item advances the midpoint circle by one
// iteration and yields 4, 8 or 12 pixel write records on pix_o, one per
// transfer, the last flagged step_last and, on the final step, circle_done too.
// A step issued with no circle loaded is accepted and dropped.
// For each group of four symmetric pixels the colour is blended channel by
// channel; each channel needs one pass of a shared restoring divider (one
// quotient bit a cycle), and each record then needs its own coordinate work;
// the time a step occupies the block is thus set mostly by the divider.
// Requests are taken only while the controller is idle; one step is worked at a
// time. Records go through a single output register, so the controller pauses
// while a record waits and the receiver holds ready low, and nothing is lost.
// Reset clears the circle state and the output valid flag; the block then ignores
// steps until a start item arrives.
module antialiased_circle_rasterizer_top import acr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  acr_req_if.sink   req_i,
  acr_pix_if.source pix_o
);

  acr_cmd_t  cmd;
  acr_stat_t stat;

  // The controller only sees status; the datapath holds every value.
  acr_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .stat_i      (stat),
    .cmd_o       (cmd),
    .req_ready_o (req_i.ready)
  );

  acr_dp u_dp (
    .clk_i,
    .rst_ni,
    .cmd_i  (cmd),
    .stat_o (stat),
    .req    (req_i),
    .pix    (pix_o)
  );

endmodule

[hdl/acr_div.sv]
// Restoring divider, one quotient bit per cycle, truncating toward zero.
`timescale 1ns / 1ps
module acr_div import acr_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic signed [DVD_W-1:0]  dividend_i,
  input  logic [DIV_W-1:0]         divisor_i,
  output logic                     done_o,
  output logic signed [DVD_W:0]    quot_o
);

  localparam int unsigned CNT_W = $clog2(DVD_W + 1);

  logic             run_q, run_d, done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DVD_W-1:0] a_q, a_d;
  logic [DIV_W-1:0] rem_q, rem_d, d_q, d_d;
  logic             neg_q, neg_d;
  logic [DIV_W:0]   trial;
  logic             fits;

  always_comb begin
    trial = {rem_q, a_q[DVD_W-1]};
    fits  = trial >= {1'b0, d_q};
    run_d = run_q;
    done_d = 1'b0;
    cnt_d = cnt_q;
    a_d = a_q;
    rem_d = rem_q;
    d_d = d_q;
    neg_d = neg_q;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = CNT_W'(DVD_W);
      a_d   = dividend_i[DVD_W-1] ? DVD_W'(-dividend_i) : DVD_W'(dividend_i);
      rem_d = '0;
      d_d   = divisor_i;
      neg_d = dividend_i[DVD_W-1];
    end else if (run_q) begin
      rem_d = fits ? DIV_W'(trial - {1'b0, d_q}) : DIV_W'(trial);
      a_d   = {a_q[DVD_W-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    rem_q <= rem_d;
    d_q   <= d_d;
    neg_q <= neg_d;
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? -$signed({1'b0, a_q}) : $signed({1'b0, a_q});

endmodule

[hdl/acr_dp.sv]
// Datapath: circle state, step arithmetic, channel blending and pixel record formation.
`timescale 1ns / 1ps
module acr_dp import acr_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  acr_cmd_t      cmd_i,
  output acr_stat_t     stat_o,
  acr_req_if.sink       req,
  acr_pix_if.source     pix
);

  // Circle state
  logic                      busy_q;
  logic [POSX_W-1:0]         pos_x_q;
  logic signed [POSY_W-1:0]  pos_y_q;
  logic signed [ERR_W-1:0]   err_q;
  logic [DIV_W-1:0]          div_q;
  logic signed [COORD_W-1:0] cx_q, cy_q;
  logic [COL_W-1:0]          fg_q, bg_q;
  logic                      wrap_q;

  // Step context
  logic signed [NUM_W-1:0] sx_q, sy_q, num_c_q, num_o_q, num_i_q;
  logic                    oen_q, ien_q, fin_q;

  // Start arithmetic
  logic [POSX_W-1:0] r_sat;

  always_comb begin
    r_sat = (POSX_W'(req.radius) > RAD_LIMIT) ? RAD_LIMIT : POSX_W'(req.radius);
  end

  // Step arithmetic
  logic signed [NUM_W-1:0] x16, y16, e16, d16, nc, no, ni, xn, yn, e1, e2;
  logic                    oc, ic;

  always_comb begin
    x16 = $signed(NUM_W'(pos_x_q));
    y16 = NUM_W'(pos_y_q);
    e16 = NUM_W'(err_q);
    d16 = $signed(NUM_W'(div_q));
    nc  = e16 + 16'sd2 * (x16 + y16) - 16'sd2;
    oc  = e16 > y16;
    no  = e16 + 16'sd2 * x16 - 16'sd1;
    xn  = oc ? x16 - 16'sd1 : x16;
    e1  = oc ? e16 - (16'sd2 * xn - 16'sd1) : e16;
    ic  = e16 <= x16;
    ni  = 16'sd1 - 16'sd2 * y16 - e16;
    yn  = ic ? y16 - 16'sd1 : y16;
    e2  = ic ? e1 - (16'sd2 * yn - 16'sd1) : e1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      pos_x_q <= '0;
      pos_y_q <= '0;
      err_q   <= '0;
      div_q   <= '0;
      cx_q    <= '0;
      cy_q    <= '0;
      fg_q    <= '0;
      bg_q    <= '0;
      wrap_q  <= 1'b0;
    end else if (cmd_i.load_start) begin
      busy_q  <= 1'b1;
      pos_x_q <= r_sat;
      pos_y_q <= '0;
      err_q   <= ERR_W'(2) - ERR_W'({r_sat, 1'b0});
      div_q   <= (r_sat != '0) ? DIV_W'({r_sat, 1'b0}) - DIV_W'(1) : DIV_W'(1);
      cx_q    <= req.center_x;
      cy_q    <= req.center_y;
      fg_q    <= req.fg_color;
      bg_q    <= req.bg_color;
      wrap_q  <= req.wrap_mode;
    end else if (cmd_i.load_step) begin
      busy_q  <= (pos_x_q != '0);
      pos_x_q <= POSX_W'(xn);
      pos_y_q <= POSY_W'(yn);
      err_q   <= ERR_W'(e2);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_step) begin
      sx_q    <= x16;
      sy_q    <= y16;
      num_c_q <= (nc < 0) ? -nc : nc;
      num_o_q <= no;
      num_i_q <= ni;
      oen_q   <= oc && (no < d16);
      ien_q   <= ic && (ni < d16);
      fin_q   <= (pos_x_q == '0);
    end
  end

  // Group operands
  logic signed [NUM_W-1:0] gu, gv, gnum;

  always_comb begin
    unique case (cmd_i.grp)
      GRP_OUTER: begin
        gu = sx_q;
        gv = sy_q - 16'sd1;
        gnum = num_o_q;
      end
      GRP_INNER: begin
        gu = sx_q - 16'sd1;
        gv = sy_q;
        gnum = num_i_q;
      end
      default: begin
        gu = sx_q;
        gv = sy_q;
        gnum = num_c_q;
      end
    endcase
  end

  // Channel blend: (cf*d - num*(cf-cb)) / d
  logic [5:0]              cf, cb;
  logic [5:0]              cmax;
  logic [17:0]             p1;
  logic signed [6:0]       diff;
  logic signed [22:0]      p2;
  logic signed [DVD_W-1:0] dvd;
  logic                    div_done;
  logic signed [DVD_W:0]   quot;
  logic [5:0]              chan_sat;
  logic [4:0]              red_q, blue_q;
  logic [5:0]              green_q;

  always_comb begin
    unique case (cmd_i.ch)
      2'd0: begin
        cf = {1'b0, fg_q[15:11]};
        cb = {1'b0, bg_q[15:11]};
        cmax = 6'd31;
      end
      2'd1: begin
        cf = fg_q[10:5];
        cb = bg_q[10:5];
        cmax = 6'd63;
      end
      default: begin
        cf = {1'b0, fg_q[4:0]};
        cb = {1'b0, bg_q[4:0]};
        cmax = 6'd31;
      end
    endcase
    p1   = 18'(cf) * 18'(div_q);
    diff = $signed({1'b0, cf}) - $signed({1'b0, cb});
    p2   = 23'(gnum) * 23'(diff);
    dvd  = $signed({6'b0, p1}) - DVD_W'(p2);
    if (quot < 0) begin
      chan_sat = '0;
    end else if (quot > $signed((DVD_W+1)'(cmax))) begin
      chan_sat = cmax;
    end else begin
      chan_sat = quot[5:0];
    end
  end

  acr_div u_div (
    .clk_i,
    .rst_ni,
    .start_i    (cmd_i.blend_start),
    .dividend_i (dvd),
    .divisor_i  (div_q),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_store) begin
      unique case (cmd_i.ch)
        2'd0:    red_q   <= chan_sat[4:0];
        2'd1:    green_q <= chan_sat;
        default: blue_q  <= chan_sat[4:0];
      endcase
    end
  end

  // Record coordinates, first cycle: sum, offset and reciprocal estimate
  logic signed [NUM_W-1:0] dx, dy;
  logic signed [SUM_W-1:0] ax_q, ay_q;
  logic [WV_W-1:0]         vx_q, vy_q, qx_q, qy_q;
  logic signed [SUM_W-1:0] ax, ay;
  logic [WV_W-1:0]         vx, vy;
  logic [31:0]             mx, my;

  always_comb begin
    unique case (cmd_i.rec)
      2'd0: begin dx = gu;  dy = -gv; end
      2'd1: begin dx = gv;  dy = gu;  end
      2'd2: begin dx = -gu; dy = gv;  end
      default: begin dx = -gv; dy = -gu; end
    endcase
    ax = SUM_W'(cx_q) + SUM_W'(dx);
    ay = SUM_W'(cy_q) + SUM_W'(dy);
    vx = WV_W'(ax) + WV_W'(OFF_X);
    vy = WV_W'(ay) + WV_W'(OFF_Y);
    mx = 32'(vx) * 32'(RECIP_X);
    my = 32'(vy) * 32'(RECIP_Y);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.coord_calc) begin
      ax_q <= ax;
      ay_q <= ay;
      vx_q <= vx;
      vy_q <= vy;
      qx_q <= WV_W'(mx >> WRAP_SH);
      qy_q <= WV_W'(my >> WRAP_SH);
    end
  end

  // Second cycle: remainder with correction, or clip test
  logic signed [WV_W:0] rx, ry;
  logic [PX_W-1:0]      px;
  logic [PY_W-1:0]      py;
  logic                 on_screen, we;

  always_comb begin
    rx = $signed({1'b0, vx_q}) - $signed((WV_W+1)'(qx_q * WV_W'(SCREEN_WIDTH)));
    ry = $signed({1'b0, vy_q}) - $signed((WV_W+1)'(qy_q * WV_W'(SCREEN_HEIGHT)));
    if (rx < 0) rx = rx + $signed((WV_W+1)'(SCREEN_WIDTH));
    if (ry < 0) ry = ry + $signed((WV_W+1)'(SCREEN_HEIGHT));
    on_screen = (ax_q >= 0) && (ax_q < $signed(SUM_W'(SCREEN_WIDTH)))
             && (ay_q >= 0) && (ay_q < $signed(SUM_W'(SCREEN_HEIGHT)));
    if (wrap_q) begin
      px = PX_W'(rx);
      py = PY_W'(ry);
      we = 1'b1;
    end else if (on_screen) begin
      px = PX_W'(ax_q);
      py = PY_W'(ay_q);
      we = 1'b1;
    end else begin
      px = '0;
      py = '0;
      we = 1'b0;
    end
  end

  // Output register
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (pix.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      pix.pixel_x      <= px;
      pix.pixel_y      <= py;
      pix.pixel_color  <= {red_q, green_q, blue_q};
      pix.write_enable <= we;
      pix.step_last    <= cmd_i.out_last;
      pix.circle_done  <= cmd_i.out_done;
    end
  end

  assign pix.valid = out_valid_q;

  always_comb begin
    stat_o.req_valid  = req.valid;
    stat_o.req_type   = req.req_type;
    stat_o.busy       = busy_q;
    stat_o.div_done   = div_done;
    stat_o.out_free   = !out_valid_q || pix.ready;
    stat_o.outer_en   = oen_q;
    stat_o.inner_en   = ien_q;
    stat_o.final_step = fin_q;
  end

endmodule

[hdl/acr_ctrl.sv]
// Controller: sequences the blend divisions and the pixel records of one step.
`timescale 1ns / 1ps
module acr_ctrl import acr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  acr_stat_t stat_i,
  output acr_cmd_t  cmd_o,
  output logic      req_ready_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_BSTART = 3'd1;
  localparam logic [2:0] S_BWAIT  = 3'd2;
  localparam logic [2:0] S_CA     = 3'd3;
  localparam logic [2:0] S_CB     = 3'd4;

  logic [2:0] state_q, state_d;
  grp_e       grp_q, grp_d;
  logic [1:0] ch_q, ch_d, rec_q, rec_d;
  logic       grp_last;
  grp_e       grp_next;

  always_comb begin
    unique case (grp_q)
      GRP_OUTER: grp_last = !stat_i.inner_en;
      GRP_INNER: grp_last = 1'b1;
      default:   grp_last = stat_i.final_step || (!stat_i.outer_en && !stat_i.inner_en);
    endcase
    grp_next = (grp_q == GRP_CURVE && stat_i.outer_en) ? GRP_OUTER : GRP_INNER;
  end

  always_comb begin
    state_d = state_q;
    grp_d   = grp_q;
    ch_d    = ch_q;
    rec_d   = rec_q;
    cmd_o   = '0;
    cmd_o.grp = grp_q;
    cmd_o.ch  = ch_q;
    cmd_o.rec = rec_q;
    req_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (stat_i.req_valid) begin
          if (stat_i.req_type == REQ_START) begin
            cmd_o.load_start = 1'b1;
          end else if (stat_i.busy) begin
            cmd_o.load_step = 1'b1;
            grp_d = GRP_CURVE;
            ch_d = 2'd0;
            state_d = S_BSTART;
          end
        end
      end
      S_BSTART: begin
        cmd_o.blend_start = 1'b1;
        state_d = S_BWAIT;
      end
      S_BWAIT: begin
        if (stat_i.div_done) begin
          cmd_o.div_store = 1'b1;
          if (ch_q == 2'd2) begin
            rec_d = 2'd0;
            state_d = S_CA;
          end else begin
            ch_d = ch_q + 2'd1;
            state_d = S_BSTART;
          end
        end
      end
      S_CA: begin
        cmd_o.coord_calc = 1'b1;
        state_d = S_CB;
      end
      S_CB: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_last = grp_last && rec_q == 2'd3;
          cmd_o.out_done = grp_last && rec_q == 2'd3 && stat_i.final_step;
          rec_d = rec_q + 2'd1;
          if (rec_q != 2'd3) begin
            state_d = S_CA;
          end else if (grp_last) begin
            state_d = S_IDLE;
          end else begin
            grp_d = grp_next;
            ch_d = 2'd0;
            state_d = S_BSTART;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      grp_q   <= GRP_CURVE;
      ch_q    <= '0;
      rec_q   <= '0;
    end else begin
      state_q <= state_d;
      grp_q   <= grp_d;
      ch_q    <= ch_d;
      rec_q   <= rec_d;
    end
  end

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> stat_i.out_free) else $error("record loaded into a full output stage");
  a_div_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_BWAIT && stat_i.div_done) |=> (state_q == S_BSTART || state_q == S_CA))
    else $error("division result not followed by next channel or record");
  a_step_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.out_load && cmd_o.out_last) |=> state_q == S_IDLE)
    else $error("controller did not return to idle after the last record");
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_done |-> cmd_o.out_last) else $error("circle done without step last");

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the anti-aliased circle rasterizer top level.
`timescale 1ns / 1ps
module tb_top;
  import acr_pkg::*;

  // One request as the sender sees it, before it is turned into a transfer.
  typedef struct {
    logic                      kind;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic [RAD_W-1:0]          rad;
    logic [COL_W-1:0]          fg;
    logic [COL_W-1:0]          bg;
    logic                      wrap;
  } circ_req_t;

  // One expected pixel write record.
  typedef struct packed {
    logic [PX_W-1:0]  px;
    logic [PY_W-1:0]  py;
    logic [COL_W-1:0] colour;
    logic             we;
    logic             last;
    logic             done;
  } pix_rec_t;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned DRAIN_WAIT  = 400;
  localparam int unsigned TAIL_ITEMS  = 40;

  logic clk_i;
  logic rst_ni;

  acr_req_if req_if ();
  acr_pix_if pix_if ();

  antialiased_circle_rasterizer_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .pix_o  (pix_if)
  );

  circ_req_t   pending_reqs[$];
  pix_rec_t    expected_pixels[$];
  circ_req_t   next_req;
  circ_req_t   taken_req;
  pix_rec_t    seen_pix;
  pix_rec_t    want_pix;
  int unsigned req_gap;
  int unsigned rx_stall;
  int unsigned accepted_reqs;
  int unsigned mismatches;
  int unsigned cycles;
  logic        hold_rx;
  logic        tail_phase;

  // Predictor state: a private copy of the circle walker.
  logic                      circ_active;
  int                        walk_x;
  int                        walk_y;
  int                        walk_err;
  int                        mix_div;
  logic signed [COORD_W-1:0] ctr_x;
  logic signed [COORD_W-1:0] ctr_y;
  logic [COL_W-1:0]          fg_col;
  logic [COL_W-1:0]          bg_col;
  logic                      wrap_on;

  always #5 clk_i = ~clk_i;

  // Exact channel blend, truncated toward zero, then clamped to the channel range.
  function automatic longint mix_chan(longint cf, longint cb, longint wnum, longint dv,
                                      longint top);
    longint q;
    q = (cf * dv - wnum * (cf - cb)) / dv;
    if (q < 0) q = 0;
    if (q > top) q = top;
    return q;
  endfunction

  function automatic logic [COL_W-1:0] blend_colour(int wnum);
    longint dv;
    longint r;
    longint g;
    longint b;
    dv = (mix_div > 0) ? mix_div : 1;
    r = mix_chan(fg_col[15:11], bg_col[15:11], wnum, dv, 31);
    g = mix_chan(fg_col[10:5], bg_col[10:5], wnum, dv, 63);
    b = mix_chan(fg_col[4:0], bg_col[4:0], wnum, dv, 31);
    return COL_W'((r << 11) | (g << 5) | b);
  endfunction

  function automatic int wrap_mod(int v, int m);
    int r;
    r = v % m;
    if (r < 0) r += m;
    return r;
  endfunction

  // Queue one pixel write, wrapped or clipped as the circle's mode says.
  function automatic void expect_pixel(int px, int py, logic [COL_W-1:0] colour);
    pix_rec_t rec;
    rec.we = 1'b1;
    if (wrap_on) begin
      px = wrap_mod(px, SCREEN_WIDTH);
      py = wrap_mod(py, SCREEN_HEIGHT);
    end else if (px < 0 || px >= SCREEN_WIDTH || py < 0 || py >= SCREEN_HEIGHT) begin
      px = 0;
      py = 0;
      rec.we = 1'b0;
    end
    rec.px = PX_W'(px);
    rec.py = PY_W'(py);
    rec.colour = colour;
    rec.last = 1'b0;
    rec.done = 1'b0;
    expected_pixels.push_back(rec);
  endfunction

  function automatic void expect_quad(int ax, int ay, int bx, int by, logic [COL_W-1:0] c);
    int x0;
    int y0;
    x0 = int'(ctr_x);
    y0 = int'(ctr_y);
    expect_pixel(x0 + ax, y0 - ay, c);
    expect_pixel(x0 + bx, y0 + by, c);
    expect_pixel(x0 - ax, y0 + ay, c);
    expect_pixel(x0 - bx, y0 - by, c);
  endfunction

  // Advance the walker by one accepted request and queue the records it causes.
  function automatic void walk_circle(circ_req_t rq);
    int wnum;
    int dv;
    int e2;
    int x2;
    int x;
    int y;
    int err;
    int r;
    if (rq.kind == REQ_START) begin
      r = int'(rq.rad);
      if (r > MAX_RADIUS) r = MAX_RADIUS;
      walk_x = r;
      walk_y = 0;
      walk_err = 2 - 2 * r;
      mix_div = (r > 0) ? 2 * r - 1 : 1;
      ctr_x = rq.cx;
      ctr_y = rq.cy;
      fg_col = rq.fg;
      bg_col = rq.bg;
      wrap_on = rq.wrap;
      circ_active = 1'b1;
      return;
    end
    if (!circ_active) return;
    x = walk_x;
    y = walk_y;
    err = walk_err;
    dv = (mix_div > 0) ? mix_div : 1;
    wnum = err + 2 * (x + y) - 2;
    if (wnum < 0) wnum = -wnum;
    // Points on the curve: (x,-y) and its three quarter-turn images.
    expect_quad(x, y, y, x, blend_colour(wnum));
    if (x == 0) begin
      // The axis points are repeated on the final step, which closes the circle.
      circ_active = 1'b0;
      expected_pixels[expected_pixels.size()-1].last = 1'b1;
      expected_pixels[expected_pixels.size()-1].done = 1'b1;
      return;
    end
    e2 = err;
    x2 = x;
    if (err > y) begin
      wnum = err + 2 * x - 1;
      if (wnum < dv) expect_quad(x, y - 1, y - 1, x, blend_colour(wnum));
      x--;
      err -= 2 * x - 1;
    end
    if (e2 <= x2) begin
      x2--;
      wnum = 1 - 2 * y - e2;
      if (wnum < dv) expect_quad(x2, y, y, x2, blend_colour(wnum));
      y--;
      err -= 2 * y - 1;
    end
    walk_x = x;
    walk_y = y;
    walk_err = err;
    expected_pixels[expected_pixels.size()-1].last = 1'b1;
  endfunction

  function automatic void add_start(int cx, int cy, int rad, int fg, int bg, int wrap);
    circ_req_t rq;
    rq.kind = REQ_START;
    rq.cx = COORD_W'(cx);
    rq.cy = COORD_W'(cy);
    rq.rad = RAD_W'(rad);
    rq.fg = COL_W'(fg);
    rq.bg = COL_W'(bg);
    rq.wrap = wrap[0];
    pending_reqs.push_back(rq);
  endfunction

  // Step items carry random junk in the start fields, which must be ignored.
  function automatic void add_steps(int count);
    circ_req_t rq;
    for (int i = 0; i < count; i++) begin
      rq.kind = REQ_STEP;
      rq.cx = COORD_W'($urandom);
      rq.cy = COORD_W'($urandom);
      rq.rad = RAD_W'($urandom);
      rq.fg = COL_W'($urandom);
      rq.bg = COL_W'($urandom);
      rq.wrap = 1'($urandom);
      pending_reqs.push_back(rq);
    end
  endfunction

  // Sender: offers queued requests, with random bursts of idle cycles.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid     <= 1'b0;
      req_if.req_type  <= REQ_START;
      req_if.center_x  <= '0;
      req_if.center_y  <= '0;
      req_if.radius    <= '0;
      req_if.fg_color  <= '0;
      req_if.bg_color  <= '0;
      req_if.wrap_mode <= 1'b0;
      req_gap          <= 0;
      tail_phase       <= 1'b0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        taken_req.kind = req_if.req_type;
        taken_req.cx   = req_if.center_x;
        taken_req.cy   = req_if.center_y;
        taken_req.rad  = req_if.radius;
        taken_req.fg   = req_if.fg_color;
        taken_req.bg   = req_if.bg_color;
        taken_req.wrap = req_if.wrap_mode;
        walk_circle(taken_req);
        accepted_reqs <= accepted_reqs + 1;
      end
      if (pending_reqs.size() < TAIL_ITEMS) tail_phase <= 1'b1;
      if (!req_if.valid || req_if.ready) begin
        if (req_gap > 0) begin
          req_gap <= req_gap - 1;
          req_if.valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          next_req = pending_reqs.pop_front();
          req_if.valid     <= 1'b1;
          req_if.req_type  <= next_req.kind;
          req_if.center_x  <= next_req.cx;
          req_if.center_y  <= next_req.cy;
          req_if.radius    <= next_req.rad;
          req_if.fg_color  <= next_req.fg;
          req_if.bg_color  <= next_req.bg;
          req_if.wrap_mode <= next_req.wrap;
          if (!tail_phase && $urandom_range(0, 3) == 0) req_gap <= $urandom_range(1, 7);
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each pixel transfer against the oldest expectation.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_if.ready <= 1'b0;
      rx_stall     <= 0;
    end else begin
      if (pix_if.valid && pix_if.ready) begin
        seen_pix.px     = pix_if.pixel_x;
        seen_pix.py     = pix_if.pixel_y;
        seen_pix.colour = pix_if.pixel_color;
        seen_pix.we     = pix_if.write_enable;
        seen_pix.last   = pix_if.step_last;
        seen_pix.done   = pix_if.circle_done;
        if (expected_pixels.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected pixel x=%0d y=%0d colour=%h we=%b last=%b done=%b",
                     seen_pix.px, seen_pix.py, seen_pix.colour, seen_pix.we,
                     seen_pix.last, seen_pix.done);
        end else begin
          want_pix = expected_pixels.pop_front();
          if (seen_pix != want_pix) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: got %0d %0d %h %b %b %b, want %0d %0d %h %b %b %b",
                       seen_pix.px, seen_pix.py, seen_pix.colour, seen_pix.we,
                       seen_pix.last, seen_pix.done, want_pix.px, want_pix.py,
                       want_pix.colour, want_pix.we, want_pix.last, want_pix.done);
          end
        end
      end
      if (hold_rx) begin
        pix_if.ready <= 1'b0;
      end else if (rx_stall > 0) begin
        rx_stall <= rx_stall - 1;
        pix_if.ready <= 1'b0;
      end else begin
        pix_if.ready <= 1'b1;
        if (!tail_phase && $urandom_range(0, 3) == 0) rx_stall <= $urandom_range(1, 7);
      end
    end
  end

  // A long hold-off on the pixel side while requests keep coming, so the block backs up.
  initial begin
    hold_rx = 1'b0;
    wait (accepted_reqs >= 60);
    @(posedge clk_i);
    hold_rx <= 1'b1;
    repeat (2000) @(posedge clk_i);
    hold_rx <= 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("antialiased_circle_rasterizer_top test failed");
      $finish;
    end
  end

  initial begin
    int rad;
    int count;
    clk_i = 1'b0;
    rst_ni = 1'b0;
    accepted_reqs = 0;
    mismatches = 0;
    cycles = 0;
    circ_active = 1'b0;
    walk_x = 0;
    walk_y = 0;
    walk_err = 0;
    mix_div = 0;
    ctr_x = '0;
    ctr_y = '0;
    fg_col = '0;
    bg_col = '0;
    wrap_on = 1'b0;

    // Directed part. A step with no circle loaded must be dropped.
    add_steps(2);
    // Radius zero: four foreground writes at the centre, clipped and wrapped.
    add_start(0, 0, 0, 16'hf81f, 16'h07e0, 0);
    add_steps(2);
    add_start(-2048, -2048, 0, 16'hffff, 16'h0000, 1);
    add_steps(1);
    // Largest radius at the far corner; abandoned by a new start while busy.
    add_start(2047, -1, 1023, 16'hffff, 16'h0000, 0);
    add_steps(3);
    add_start(-1, 2047, 1023, 16'h0000, 16'hffff, 1);
    add_steps(2);
    // A small wrapped circle straddling the screen edge, run to completion.
    add_start(381, 2, 5, 16'h0000, 16'hffff, 1);
    add_steps(10);
    count = pending_reqs.size();

    // Random part: mostly well-formed circles run to the end, a few large ones abandoned.
    while (count < 420) begin
      if ($urandom_range(0, 9) == 0) begin
        add_start($urandom_range(0, 4095) - 2048, $urandom_range(0, 4095) - 2048,
                  $urandom_range(0, 1023), $urandom, $urandom, $urandom_range(0, 1));
        rad = $urandom_range(1, 5);
        add_steps(rad);
      end else begin
        rad = $urandom_range(0, 20);
        add_start($urandom_range(0, 420) - 20, $urandom_range(0, 250) - 20, rad,
                  $urandom, $urandom, $urandom_range(0, 1));
        rad = ($urandom_range(0, 4) == 0) ? $urandom_range(1, rad + 1) : 2 * rad + 3;
        add_steps(rad);
      end
      count += rad + 1;
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(posedge clk_i);
    while (pending_reqs.size() != 0 || req_if.valid || expected_pixels.size() != 0);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    if (mismatches == 0 && expected_pixels.size() == 0) begin
      $display("antialiased_circle_rasterizer_top test passed");
    end else begin
      $display("antialiased_circle_rasterizer_top test failed");
    end
    $finish;
  end

endmodule

[files.f]
hdl/acr_pkg.sv
hdl/acr_req_if.sv
hdl/acr_pix_if.sv
hdl/acr_div.sv
hdl/acr_dp.sv
hdl/acr_ctrl.sv
hdl/antialiased_circle_rasterizer_top.sv
tb/tb_top.sv
